// ----- rtl/krht_pkg.sv -----
package krht_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 64;
  localparam int NAME_MAX = 16;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP  = 2'd1;
  localparam logic [1:0] REQ_RETAIN  = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_HELD      = 2'd3;

  typedef struct packed {
    logic               occupied;
    logic               tombstone;
    logic [COUNT_W-1:0] ref_count;
  } meta_t;

  typedef struct packed {
    logic [WORD_W-1:0] name_low;
    logic [WORD_W-1:0] name_high;
    logic [WORD_W-1:0] payload;
  } entry_t;

endpackage

// ----- rtl/name_keyed_refcount_hash_table_unit.sv -----
// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------------------
// request   | in_valid / in_ready | req_type, name_low, name_high, payload_in
// result    | out_valid/out_ready | status, payload_out, ref_count_out
//
// One request is in flight at a time. The hash registers the byte sum, the
// reciprocal multiply and the remainder giving home slot and step; then the
// home slot is read, the probe walks the chain one slot per cycle through the
// slot memory read port, and the result is loaded into the output register.
// An empty name answers without probing; the next request is taken once its
// result is loaded. After reset the slot flags and counts are swept to zero
// with in_ready low. A stalled result holds the finished request.
module name_keyed_refcount_hash_table_unit #(
  parameter int TABLE_SLOTS = 251,
  parameter int NAME_BYTES  = 16,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   req_type,
  input  logic [krht_pkg::WORD_W-1:0]  name_low,
  input  logic [krht_pkg::WORD_W-1:0]  name_high,
  input  logic [krht_pkg::WORD_W-1:0]  payload_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [krht_pkg::WORD_W-1:0]  payload_out,
  output logic [krht_pkg::COUNT_W-1:0] ref_count_out
);
  import krht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;

  // request held for the whole walk
  logic [1:0]         req_q;
  logic [WORD_W-1:0]  payload_q;

  // probe chain position
  logic [SLOT_W-1:0]  loc;
  logic [SLOT_W-1:0]  step_q;
  logic [SLOT_W-1:0]  probe_n;
  logic [SLOT_W-1:0]  total;

  // finished result waiting for the output register
  logic [1:0]         res_status;
  logic [WORD_W-1:0]  res_payload;
  logic [COUNT_W-1:0] res_count;
  logic               resp_load;

  // hash unit
  logic               hash_start;
  logic               hash_done;
  logic               name_empty;
  logic [WORD_W-1:0]  canon_low;
  logic [WORD_W-1:0]  canon_high;
  logic [SLOT_W-1:0]  home;
  logic [SLOT_W-1:0]  step;

  // slot store
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  meta_t              rd_meta;
  entry_t             rd_entry;
  logic               wr_meta_en;
  logic               wr_entry_en;
  meta_t              wr_meta;
  entry_t             wr_entry;
  logic               clr_done;

  // probe decision
  logic               hit_name;
  logic               free_slot;
  logic               last_probe;
  logic [COUNT_W-1:0] count_up;
  logic [COUNT_W-1:0] count_dn;
  logic [SLOT_W:0]    loc_sum;
  logic [SLOT_W-1:0]  next_loc;
  logic               finish;
  logic               advance;
  logic               count_total;
  logic [1:0]         fin_status;
  logic [WORD_W-1:0]  fin_payload;
  logic [COUNT_W-1:0] fin_count;

  assign in_ready   = (state == S_IDLE);
  assign hash_start = in_valid && in_ready;

  // load the output register once the previous result has gone
  assign resp_load  = (state == S_RESP) && (!out_valid || out_ready);

  krht_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NAME_BYTES  (NAME_BYTES)
  ) u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (hash_start),
    .name_low   (name_low),
    .name_high  (name_high),
    .done       (hash_done),
    .name_empty (name_empty),
    .canon_low  (canon_low),
    .canon_high (canon_high),
    .home       (home),
    .step       (step)
  );

  krht_store #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_meta     (rd_meta),
    .rd_entry    (rd_entry),
    .wr_meta_en  (wr_meta_en),
    .wr_entry_en (wr_entry_en),
    .wr_addr     (loc),
    .wr_meta     (wr_meta),
    .wr_entry    (wr_entry),
    .clr_done    (clr_done)
  );

  // next slot on the chain: both terms are below TABLE_SLOTS, so one
  // conditional subtract wraps it
  always_comb begin
    loc_sum  = {1'b0, loc} + {1'b0, step_q};
    next_loc = (loc_sum >= (SLOT_W + 1)'(TABLE_SLOTS))
             ? SLOT_W'(loc_sum - (SLOT_W + 1)'(TABLE_SLOTS))
             : loc_sum[SLOT_W-1:0];
  end

  assign hit_name   = rd_meta.occupied && !rd_meta.tombstone &&
                      (rd_entry.name_low == canon_low) &&
                      (rd_entry.name_high == canon_high);
  assign free_slot  = !rd_meta.occupied || rd_meta.tombstone;
  assign last_probe = (probe_n == SLOT_W'(TABLE_SLOTS - 1));
  assign count_up   = (rd_meta.ref_count == COUNT_MAX) ? rd_meta.ref_count
                                                       : rd_meta.ref_count + COUNT_W'(1);
  assign count_dn   = rd_meta.ref_count - COUNT_W'(1);

  assign wr_entry = '{name_low: canon_low, name_high: canon_high, payload: payload_q};

  // Examine the slot read last cycle: stop with a result, or move on along
  // the chain. The slot update is written back in the same cycle.
  always_comb begin
    finish      = 1'b0;
    advance     = 1'b0;
    count_total = 1'b0;
    fin_status  = ST_NOT_FOUND;
    fin_payload = '0;
    fin_count   = '0;
    wr_meta_en  = 1'b0;
    wr_entry_en = 1'b0;
    wr_meta     = rd_meta;
    if (state == S_PROBE) begin
      if (req_q == REQ_INSERT) begin
        if (free_slot) begin
          finish = 1'b1;
          if (!rd_meta.occupied && (total >= SLOT_W'(TABLE_SLOTS - 1))) begin
            fin_status = ST_FULL;
          end else begin
            fin_status  = ST_OK;
            fin_count   = count_up;
            wr_meta_en  = 1'b1;
            wr_entry_en = 1'b1;
            wr_meta     = '{occupied: 1'b1, tombstone: 1'b0, ref_count: count_up};
            count_total = !rd_meta.occupied;
          end
        end else if (last_probe) begin
          finish     = 1'b1;
          fin_status = ST_FULL;
        end else begin
          advance = 1'b1;
        end
      end else begin
        if (!rd_meta.occupied) begin
          finish = 1'b1;
        end else if (hit_name) begin
          finish = 1'b1;
          if (req_q == REQ_RELEASE) begin
            wr_meta_en = 1'b1;
            if (rd_meta.ref_count <= COUNT_W'(1)) begin
              // final release: tombstone the slot and hand back the record
              wr_meta.ref_count = '0;
              wr_meta.tombstone = 1'b1;
              fin_status        = ST_OK;
              fin_payload       = rd_entry.payload;
            end else begin
              wr_meta.ref_count = count_dn;
              fin_status        = ST_HELD;
              fin_count         = count_dn;
            end
          end else begin
            fin_status  = ST_OK;
            fin_payload = rd_entry.payload;
            if (req_q == REQ_RETAIN) begin
              wr_meta_en        = 1'b1;
              wr_meta.ref_count = count_up;
              fin_count         = count_up;
            end else if (req_q == REQ_LOOKUP) begin
              fin_count = rd_meta.ref_count;
            end
          end
        end else if (last_probe) begin
          finish = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
    end
  end

  // read the home slot when the hash lands for a non-empty name, then one slot per probe
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = loc;
    if (state == S_HASH && hash_done && !name_empty) begin
      rd_en   = 1'b1;
      rd_addr = home;
    end else if (advance) begin
      rd_en   = 1'b1;
      rd_addr = next_loc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_HASH;
        end
        S_HASH: begin
          if (hash_done) begin
            state <= name_empty ? S_RESP : S_PROBE;
          end
        end
        S_PROBE: begin
          if (finish) state <= S_RESP;
          if (count_total) total <= total + SLOT_W'(1);
        end
        S_RESP: begin
          if (resp_load) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hash_start) begin
      req_q     <= req_type;
      payload_q <= payload_in;
    end
    if (state == S_HASH && hash_done) begin
      loc         <= home;
      step_q      <= step;
      probe_n     <= '0;
      res_status  <= ST_NOT_FOUND;
      res_payload <= '0;
      res_count   <= '0;
    end
    if (advance) begin
      loc     <= next_loc;
      probe_n <= probe_n + SLOT_W'(1);
    end
    if (finish) begin
      res_status  <= fin_status;
      res_payload <= fin_payload;
      res_count   <= fin_count;
    end
    if (resp_load) begin
      status        <= res_status;
      payload_out   <= res_payload;
      ref_count_out <= res_count;
    end
  end

  // apart from the clearing sweep, slot memory is written only while a probe decides
  a_write_in_probe: assert property (@(posedge clk) disable iff (rst)
    (wr_meta_en || wr_entry_en) |-> (state == S_PROBE))
    else $error("slot written outside a probe");

  // the hash unit finishes only while the walk waits for it
  a_hash_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash result arrived with no walk waiting");

  // used slot count never passes the fill limit
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= SLOT_W'(TABLE_SLOTS - 1))
    else $error("used slot count beyond fill limit");

  // no request before the clearing sweep is over
  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> clr_done)
    else $error("request taken during clearing sweep");

  // a successful insert always leaves a live reference
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && req_q == REQ_INSERT && res_status == ST_OK)
      |-> (res_count != '0))
    else $error("insert finished with zero reference count");

endmodule

// ----- rtl/krht_hash.sv -----
module krht_hash #(
  parameter int TABLE_SLOTS = 251,
  parameter int NAME_BYTES  = 16,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [krht_pkg::WORD_W-1:0] name_low,
  input  logic [krht_pkg::WORD_W-1:0] name_high,
  output logic                        done,
  output logic                        name_empty,
  output logic [krht_pkg::WORD_W-1:0] canon_low,
  output logic [krht_pkg::WORD_W-1:0] canon_high,
  output logic [SLOT_W-1:0]           home,
  output logic [SLOT_W-1:0]           step
);
  import krht_pkg::*;

  localparam int SUM_MAX = NAME_BYTES * 255;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int RAW_W   = NAME_MAX * BYTE_W;

  // reciprocal scale: the quotient is exact for every sum below 2**SUM_W
  localparam int REC_K   = SUM_W + SLOT_W;
  localparam int PROD_W  = SUM_W + REC_K;
  localparam int REM_W   = SUM_W + SLOT_W + 1;

  localparam longint HOME_DIV = longint'(TABLE_SLOTS);
  localparam longint STEP_DIV = longint'(TABLE_SLOTS - 2);
  localparam longint HOME_REC = ((longint'(1) << REC_K) + HOME_DIV - 1) / HOME_DIV;
  localparam longint STEP_REC = ((longint'(1) << REC_K) + STEP_DIV - 1) / STEP_DIV;

  function automatic logic [NAME_MAX-1:0] upto_mask(input int idx);
    logic [NAME_MAX-1:0] m;
    m = '0;
    for (int k = 0; k < NAME_MAX; k++) begin
      if (k <= idx) m[k] = 1'b1;
    end
    return m;
  endfunction

  logic [RAW_W-1:0]    raw;
  logic [NAME_MAX-1:0] nz;
  logic [NAME_MAX-1:0] keep;
  logic [RAW_W-1:0]    canon;
  logic [SUM_W-1:0]    quad_sum [4];
  logic [SUM_W-1:0]    sum;

  logic [RAW_W-1:0]    canon_q;
  logic [SUM_W-1:0]    sum_q;
  logic                sum_vld;
  logic                quo_vld;
  logic [PROD_W-1:0]   home_prod;
  logic [PROD_W-1:0]   step_prod;
  logic [SUM_W-1:0]    quo_home;
  logic [SUM_W-1:0]    quo_step;
  logic [REM_W-1:0]    home_rem;
  logic [REM_W-1:0]    step_rem;
  logic [SLOT_W-1:0]   rem_home;
  logic [SLOT_W-1:0]   rem_step;

  // cut the name at its first zero byte or after NAME_BYTES bytes, then sum the kept bytes in a tree
  always_comb begin
    raw = {name_high, name_low};
    for (int i = 0; i < NAME_MAX; i++) begin
      nz[i] = (raw[i*BYTE_W +: BYTE_W] != '0);
    end
    for (int i = 0; i < NAME_MAX; i++) begin
      keep[i] = (i < NAME_BYTES) && ((nz & upto_mask(i)) == upto_mask(i));
      canon[i*BYTE_W +: BYTE_W] = keep[i] ? raw[i*BYTE_W +: BYTE_W] : '0;
    end
    for (int q = 0; q < 4; q++) begin
      quad_sum[q] = '0;
      for (int k = 0; k < 4; k++) begin
        quad_sum[q] = quad_sum[q] + SUM_W'(canon[(q*4+k)*BYTE_W +: BYTE_W]);
      end
    end
    sum = (quad_sum[0] + quad_sum[1]) + (quad_sum[2] + quad_sum[3]);
  end

  // quotient by reciprocal multiplication, then remainder by one multiply-subtract
  always_comb begin
    home_prod = PROD_W'(sum_q) * PROD_W'(HOME_REC);
    step_prod = PROD_W'(sum_q) * PROD_W'(STEP_REC);
    home_rem  = REM_W'(sum_q) - REM_W'(quo_home) * REM_W'(HOME_DIV);
    step_rem  = REM_W'(sum_q) - REM_W'(quo_step) * REM_W'(STEP_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
      quo_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      sum_vld <= start;
      quo_vld <= sum_vld;
      done    <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      canon_q <= canon;
      sum_q   <= sum;
    end
    if (sum_vld) begin
      quo_home <= home_prod[REC_K +: SUM_W];
      quo_step <= step_prod[REC_K +: SUM_W];
    end
    if (quo_vld) begin
      rem_home <= home_rem[SLOT_W-1:0];
      rem_step <= step_rem[SLOT_W-1:0];
    end
  end

  assign canon_low  = canon_q[WORD_W-1:0];
  assign canon_high = canon_q[RAW_W-1:WORD_W];
  assign name_empty = (canon_q[BYTE_W-1:0] == '0);
  assign home       = rem_home;
  assign step       = (rem_step == '0) ? SLOT_W'(1) : rem_step;

endmodule

// ----- rtl/krht_store.sv -----
module krht_store #(
  parameter int TABLE_SLOTS = 251,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [SLOT_W-1:0]    rd_addr,
  output krht_pkg::meta_t      rd_meta,
  output krht_pkg::entry_t     rd_entry,
  input  logic                 wr_meta_en,
  input  logic                 wr_entry_en,
  input  logic [SLOT_W-1:0]    wr_addr,
  input  krht_pkg::meta_t      wr_meta,
  input  krht_pkg::entry_t     wr_entry,
  output logic                 clr_done
);
  import krht_pkg::*;

  meta_t  meta_mem  [TABLE_SLOTS];
  entry_t entry_mem [TABLE_SLOTS];

  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  // sweep the slot flags and counts to zero, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      meta_mem[clr_addr] <= '0;
    end else if (wr_meta_en) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (rd_en) begin
      rd_meta <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_entry_en) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= entry_mem[rd_addr];
    end
  end

  assign clr_done = !clr_busy;

endmodule
